// ===== rtl/psu_pkg.sv =====
// shared types and constants for the periodic update scheduler
package psu_pkg;

    localparam int ID_W    = 32;
    localparam int MS_W    = 16;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [MS_W-1:0] MAX_DELAY_RESET = 16'd1000;
    localparam logic [MS_W-1:0] MIN_DELAY_RESET = 16'd1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FIRE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELAY      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL       = 2'd3;

    // request types
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    // register indexes, decoded from paddr[2]
    localparam logic REG_MAX_DELAY = 1'b0;
    localparam logic REG_MIN_DELAY = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0] max_delay;
        logic [MS_W-1:0] min_delay;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0] key;
        logic [MS_W-1:0] period;
        logic [MS_W-1:0] countdown;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic            fire;
        logic [MS_W-1:0] new_countdown;
        logic            lower;
    } alu_res_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

// ===== rtl/psu_ram.sv =====
// generic single write port ram with registered read
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/psu_cfg.sv =====
// apb configuration registers for the scheduler
module psu_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psu_pkg::ADDR_W-1:0]  paddr,
    input  logic [psu_pkg::DATA_W-1:0]  pwdata,
    output logic [psu_pkg::DATA_W-1:0]  prdata,
    output psu_pkg::cfg_t               cfg
);

    logic [psu_pkg::MS_W-1:0] max_delay_reg;
    logic [psu_pkg::MS_W-1:0] min_delay_reg;
    logic                     wr_en;

    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delay_reg <= psu_pkg::MAX_DELAY_RESET;
            min_delay_reg <= psu_pkg::MIN_DELAY_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                psu_pkg::REG_MAX_DELAY: max_delay_reg <= pwdata[psu_pkg::MS_W-1:0];
                psu_pkg::REG_MIN_DELAY: min_delay_reg <= pwdata[psu_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            psu_pkg::REG_MAX_DELAY:
                prdata = {{(psu_pkg::DATA_W-psu_pkg::MS_W){1'b0}}, max_delay_reg};
            psu_pkg::REG_MIN_DELAY:
                prdata = {{(psu_pkg::DATA_W-psu_pkg::MS_W){1'b0}}, min_delay_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.max_delay = max_delay_reg;
    assign cfg.min_delay = min_delay_reg;

endmodule

// ===== rtl/psu_alu.sv =====
// shared countdown unit: subtract elapsed time, detect expiry, reload, track minimum
module psu_alu (
    input  logic [psu_pkg::MS_W-1:0] countdown,
    input  logic [psu_pkg::MS_W-1:0] period,
    input  logic [psu_pkg::MS_W-1:0] elapsed,
    input  logic [psu_pkg::MS_W-1:0] min_cur,
    output psu_pkg::alu_res_t        res
);

    logic [psu_pkg::MS_W+1:0] diff;
    logic [psu_pkg::MS_W-1:0] new_cd;
    logic                     fire;

    always_comb
    begin
        diff   = {2'b00, countdown} - {2'b00, elapsed};
        // expired when the difference is negative or exactly zero
        fire   = diff[psu_pkg::MS_W+1] | (diff == '0);
        new_cd = fire ? period : diff[psu_pkg::MS_W-1:0];
        res.fire          = fire;
        res.new_countdown = new_cd;
        res.lower         = new_cd < min_cur;
    end

endmodule

// ===== rtl/periodic_update_scheduler_top.sv =====
// periodic update scheduler: id table walked one entry per cycle by a small sequencer,
// except while a result waits for the output register to be free
// throughput: one item at a time; a register item walks entries until a hit (all
//   entries on a miss), a tick walks every entry, and each also stalls on the output
//   the walk rate is set by the single table read port and the shared countdown unit
// reset: entry count cleared, max/min delay registers to 1000 / 1, table contents undefined
module periodic_update_scheduler_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [psu_pkg::ID_W-1:0]     obj_id,
    input  logic [psu_pkg::MS_W-1:0]     period_ms,
    input  logic [psu_pkg::MS_W-1:0]     elapsed_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [psu_pkg::KIND_W-1:0]   kind,
    output logic [psu_pkg::ID_W-1:0]     fired_id,
    output logic [psu_pkg::MS_W-1:0]     next_delay_ms,
    output logic                         last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psu_pkg::ADDR_W-1:0]   paddr,
    input  logic [psu_pkg::DATA_W-1:0]   pwdata,
    output logic [psu_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    psu_pkg::cfg_t     cfg;
    psu_pkg::alu_res_t alu;
    psu_pkg::state_t   state_reg;
    psu_pkg::state_t   state_next;
    psu_pkg::entry_t   rd_entry;
    psu_pkg::entry_t   wr_entry;

    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic [CW-1:0]                idx_inc;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [psu_pkg::MS_W-1:0]     min_reg;
    logic [psu_pkg::MS_W-1:0]     min_next;
    logic [psu_pkg::MS_W-1:0]     delay_clamped;

    logic                         req_reg;
    logic [psu_pkg::ID_W-1:0]     id_reg;
    logic [psu_pkg::MS_W-1:0]     period_reg;
    logic [psu_pkg::MS_W-1:0]     elapsed_reg;

    logic                         out_valid_reg;
    logic [psu_pkg::KIND_W-1:0]   kind_reg;
    logic [psu_pkg::ID_W-1:0]     fired_id_reg;
    logic [psu_pkg::MS_W-1:0]     delay_reg;
    logic                         last_reg;

    logic                         out_free;
    logic                         accept;
    logic                         last_entry;
    logic                         emit;
    logic [psu_pkg::KIND_W-1:0]   emit_kind;
    logic [psu_pkg::ID_W-1:0]     emit_id;
    logic [psu_pkg::MS_W-1:0]     emit_delay;
    logic                         emit_last;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [psu_pkg::ENTRY_W-1:0]  rd_data;

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == psu_pkg::S_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign idx_inc   = idx_reg + CW'(1);
    assign last_entry = (idx_inc == count_reg);
    assign rd_entry  = psu_pkg::entry_t'(rd_data);
    assign delay_clamped = (min_reg < cfg.min_delay) ? cfg.min_delay : min_reg;

    psu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    psu_alu u_alu (
        .countdown (rd_entry.countdown),
        .period    (rd_entry.period),
        .elapsed   (elapsed_reg),
        .min_cur   (min_reg),
        .res       (alu)
    );

    // read address follows the next index so entry data is ready when the index lands
    psu_ram #(
        .WIDTH (psu_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (idx_next[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        min_next   = min_reg;
        emit       = 1'b0;
        emit_kind  = psu_pkg::KIND_FIRE;
        emit_id    = '0;
        emit_delay = '0;
        emit_last  = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wr_entry   = rd_entry;

        case (state_reg)
            psu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    min_next   = cfg.max_delay;
                    state_next = (count_reg == '0) ? psu_pkg::S_FIN : psu_pkg::S_WALK;
                end
            end

            psu_pkg::S_WALK:
            begin
                if (req_reg == psu_pkg::REQ_REGISTER)
                begin
                    if (rd_entry.key == id_reg)
                    begin
                        if (out_free)
                        begin
                            we                 = 1'b1;
                            wr_entry.period    = period_reg;
                            wr_entry.countdown = '0;
                            emit       = 1'b1;
                            emit_kind  = psu_pkg::KIND_REGISTERED;
                            emit_id    = id_reg;
                            emit_last  = 1'b1;
                            state_next = psu_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        if (last_entry)
                        begin
                            state_next = psu_pkg::S_FIN;
                        end
                    end
                end
                else if (rd_entry.period == '0)
                begin
                    idx_next = idx_inc;
                    if (last_entry)
                    begin
                        state_next = psu_pkg::S_FIN;
                    end
                end
                else if (!alu.fire || out_free)
                begin
                    we                 = 1'b1;
                    wr_entry.countdown = alu.new_countdown;
                    if (alu.fire)
                    begin
                        emit      = 1'b1;
                        emit_kind = psu_pkg::KIND_FIRE;
                        emit_id   = rd_entry.key;
                    end
                    if (alu.lower)
                    begin
                        min_next = alu.new_countdown;
                    end
                    idx_next = idx_inc;
                    if (last_entry)
                    begin
                        state_next = psu_pkg::S_FIN;
                    end
                end
            end

            psu_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = psu_pkg::S_IDLE;
                    if (req_reg == psu_pkg::REQ_TICK)
                    begin
                        emit_kind  = psu_pkg::KIND_DELAY;
                        emit_delay = delay_clamped;
                    end
                    else if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        emit_kind = psu_pkg::KIND_FULL;
                        emit_id   = id_reg;
                    end
                    else
                    begin
                        // new id goes to the first free slot
                        we                 = 1'b1;
                        waddr              = count_reg[AW-1:0];
                        wr_entry.key       = id_reg;
                        wr_entry.period    = period_reg;
                        wr_entry.countdown = '0;
                        count_next         = count_reg + CW'(1);
                        emit_kind          = psu_pkg::KIND_REGISTERED;
                        emit_id            = id_reg;
                    end
                end
            end

            default:
            begin
                state_next = psu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psu_pkg::S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        if (accept)
        begin
            req_reg     <= req_type;
            id_reg      <= obj_id;
            period_reg  <= period_ms;
            elapsed_reg <= elapsed_ms;
        end
        if (emit)
        begin
            kind_reg     <= emit_kind;
            fired_id_reg <= emit_id;
            delay_reg    <= emit_delay;
            last_reg     <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign fired_id      = fired_id_reg;
    assign next_delay_ms = delay_reg;
    assign last          = last_reg;

endmodule
